[sv/ltdq_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LED temporal dither quantizer package
// Shared widths, word types, register indexes and scale constants.
// ---------------------------------------------------------------------------
package ltdq_pkg;

    localparam int LEVEL_W  = 17;
    localparam int FRAC_W   = 16;
    localparam int INDEX_W  = 10;
    localparam int DRIVE_W  = 8;
    localparam int PHASE_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W   = LEVEL_W + DRIVE_W;

    localparam logic [LEVEL_W-1:0] FULL_SCALE   = 17'd65536;
    localparam logic [DRIVE_W-1:0] DITHER_SCALE = 8'd254;
    localparam logic [DRIVE_W-1:0] PLAIN_SCALE  = 8'd255;

    localparam logic [CFG_IDX_W-1:0] REG_DITHER_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_ZERO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_ONE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_TWO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_THREE = 3'd4;

    localparam logic [FRAC_W-1:0] THRESHOLD_ZERO_RST  = 16'd8192;
    localparam logic [FRAC_W-1:0] THRESHOLD_ONE_RST   = 16'd24576;
    localparam logic [FRAC_W-1:0] THRESHOLD_TWO_RST   = 16'd40960;
    localparam logic [FRAC_W-1:0] THRESHOLD_THREE_RST = 16'd57344;

    typedef struct packed {
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
        logic [INDEX_W-1:0] pixel_index;
        logic               frame_start;
    } pixel_in_t;

    typedef struct packed {
        logic [DRIVE_W-1:0] out_red;
        logic [DRIVE_W-1:0] out_green;
        logic [DRIVE_W-1:0] out_blue;
    } pixel_out_t;

endpackage

[sv/ltdq_pixel_in_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Input pixel channel
// Valid/ready channel that carries one Q16 RGB pixel word.
// ---------------------------------------------------------------------------
interface ltdq_pixel_in_if;
    import ltdq_pkg::*;

    logic      valid;
    logic      ready;
    pixel_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/ltdq_pixel_out_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Output pixel channel
// Valid/ready channel that carries one 8-bit RGB drive word.
// ---------------------------------------------------------------------------
interface ltdq_pixel_out_if;
    import ltdq_pkg::*;

    logic       valid;
    logic       ready;
    pixel_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/led_temporal_dither_quantizer.sv]
`timescale 1ns / 1ps
// A word accepted into the input register moves on to the result register,
// from which the sink takes it. Throughput: one pixel word per clock while
// the sink keeps up. While the sink stalls, the input register still takes
// one more word, then the input stalls until the sink drains the result
// register. Reset: rst_n clears the pipeline valids and the frame phase,
// sets dither on and loads thresholds 8192, 24576, 40960, 57344.
// ---------------------------------------------------------------------------
// LED temporal dither quantizer
// Clamps each Q16 color level, then scales it to 8 bits with four-phase
// ordered temporal dithering or with plain truncation.
// ---------------------------------------------------------------------------
module led_temporal_dither_quantizer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ltdq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ltdq_pkg::CFG_DATA_W-1:0] cfg_data,
    ltdq_pixel_in_if.sink                   pix_in,
    ltdq_pixel_out_if.source                pix_out
);
    import ltdq_pkg::*;

    // Registers the user changes only with the pipeline empty; not enforced.
    logic              dither_en_reg;
    logic [FRAC_W-1:0] threshold_reg [4];

    // Frame phase, stepped on an accepted frame-start word while dither is on,
    // so that the first pixel of the frame already uses the new phase.
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [PHASE_W-1:0] slot_next;

    // Input register stage: clamped levels and the chosen threshold slot.
    logic               s1_valid_reg;
    logic [LEVEL_W-1:0] s1_red_reg;
    logic [LEVEL_W-1:0] s1_green_reg;
    logic [LEVEL_W-1:0] s1_blue_reg;
    logic [PHASE_W-1:0] s1_slot_reg;

    // Result register stage.
    logic       out_valid_reg;
    pixel_out_t out_data_reg;
    pixel_out_t out_data_next;

    logic              in_fire;
    logic              s1_advance;
    logic [FRAC_W-1:0] threshold_sel;

    function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] v);
        clamp_level = (v > FULL_SCALE) ? FULL_SCALE : v;
    endfunction

    // The input stage moves on when the result register is empty or is
    // being drained this cycle; a word enters if stage one is empty or moves.
    assign s1_advance   = !out_valid_reg || pix_out.ready;
    assign pix_in.ready = !s1_valid_reg || s1_advance;
    assign in_fire      = pix_in.valid && pix_in.ready;

    assign phase_next = phase_reg +
                        {{(PHASE_W-1){1'b0}}, pix_in.data.frame_start & dither_en_reg};
    assign slot_next  = phase_next + pix_in.data.pixel_index[PHASE_W-1:0];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            dither_en_reg    <= 1'b1;
            threshold_reg[0] <= THRESHOLD_ZERO_RST;
            threshold_reg[1] <= THRESHOLD_ONE_RST;
            threshold_reg[2] <= THRESHOLD_TWO_RST;
            threshold_reg[3] <= THRESHOLD_THREE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DITHER_ENABLE:   dither_en_reg    <= cfg_data[0];
                REG_THRESHOLD_ZERO:  threshold_reg[0] <= cfg_data;
                REG_THRESHOLD_ONE:   threshold_reg[1] <= cfg_data;
                REG_THRESHOLD_TWO:   threshold_reg[2] <= cfg_data;
                REG_THRESHOLD_THREE: threshold_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg <= phase_next;
            end
            if (pix_in.ready)
            begin
                s1_valid_reg <= pix_in.valid;
            end
            if (s1_advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (in_fire)
        begin
            s1_red_reg   <= clamp_level(pix_in.data.red_level);
            s1_green_reg <= clamp_level(pix_in.data.green_level);
            s1_blue_reg  <= clamp_level(pix_in.data.blue_level);
            s1_slot_reg  <= slot_next;
        end
        if (s1_advance && s1_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // One threshold serves all three channels of the pixel.
    assign threshold_sel = threshold_reg[s1_slot_reg];

    ltdq_channel_quant u_quant_red (
        .level     (s1_red_reg),
        .dither_en (dither_en_reg),
        .threshold (threshold_sel),
        .drive     (out_data_next.out_red)
    );

    ltdq_channel_quant u_quant_green (
        .level     (s1_green_reg),
        .dither_en (dither_en_reg),
        .threshold (threshold_sel),
        .drive     (out_data_next.out_green)
    );

    ltdq_channel_quant u_quant_blue (
        .level     (s1_blue_reg),
        .dither_en (dither_en_reg),
        .threshold (threshold_sel),
        .drive     (out_data_next.out_blue)
    );

    assign pix_out.valid = out_valid_reg;
    assign pix_out.data  = out_data_reg;
endmodule

[sv/ltdq_channel_quant.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Channel quantizer
// Scales one clamped Q16 level to an 8-bit drive value, with optional
// threshold rounding of the fraction.
// ---------------------------------------------------------------------------
module ltdq_channel_quant (
    input  logic [ltdq_pkg::LEVEL_W-1:0] level,
    input  logic                         dither_en,
    input  logic [ltdq_pkg::FRAC_W-1:0]  threshold,
    output logic [ltdq_pkg::DRIVE_W-1:0] drive
);
    import ltdq_pkg::*;

    logic [DRIVE_W-1:0] scale;
    logic [PROD_W-1:0]  prod;
    logic [DRIVE_W-1:0] whole;
    logic               round_up;

    assign scale = dither_en ? DITHER_SCALE : PLAIN_SCALE;
    assign prod  = {{DRIVE_W{1'b0}}, level} * {{LEVEL_W{1'b0}}, scale};
    assign whole = prod[FRAC_W +: DRIVE_W];

    // The product never exceeds 255 in its integer part, and a raised value
    // stays within eight bits because full scale with dither gives 254.
    assign round_up = dither_en && (prod[FRAC_W-1:0] >= threshold);
    assign drive    = whole + {{(DRIVE_W-1){1'b0}}, round_up};
endmodule

[sim/ltdq_drive_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Drive word checker
// Watches the configuration port and both pixel channels. It predicts the
// 8-bit drive word for every accepted input word and compares it with the
// words that leave the quantizer, oldest first.
// ---------------------------------------------------------------------------
module ltdq_drive_checker
    import ltdq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  pixel_in_t             in_word,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  pixel_out_t            out_word,
    output int                    mismatch_count,
    output int                    pending_words
);

    localparam int REPORT_LIMIT = 10;

    logic               dither_on;
    logic [FRAC_W-1:0]  slot_threshold [4];
    logic [PHASE_W-1:0] frame_phase;
    pixel_out_t         expected_drive [$];

    // Clamp a Q16 level to full scale, then scale it to eight bits.
    function automatic logic [DRIVE_W-1:0] scale_level(
        input logic [LEVEL_W-1:0] level,
        input logic [FRAC_W-1:0]  threshold,
        input logic               dither
    );
        logic [LEVEL_W-1:0]       clamped;
        logic [PROD_W-1:0]        product;
        logic [PROD_W-FRAC_W-1:0] whole;
        clamped = (level > FULL_SCALE) ? FULL_SCALE : level;
        product = clamped * (dither ? DITHER_SCALE : PLAIN_SCALE);
        whole   = product[PROD_W-1:FRAC_W];
        if (dither && product[FRAC_W-1:0] >= threshold)
            whole = whole + 1'b1;
        return whole[DRIVE_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        logic [PHASE_W-1:0] slot;
        logic [FRAC_W-1:0]  threshold;
        pixel_out_t         drive;
        pixel_out_t         want;
        if (!rst_n)
        begin
            dither_on         = 1'b1;
            slot_threshold[0] = THRESHOLD_ZERO_RST;
            slot_threshold[1] = THRESHOLD_ONE_RST;
            slot_threshold[2] = THRESHOLD_TWO_RST;
            slot_threshold[3] = THRESHOLD_THREE_RST;
            frame_phase       = '0;
            expected_drive.delete();
            mismatch_count    = 0;
            pending_words     = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DITHER_ENABLE:   dither_on = cfg_data[0];
                    REG_THRESHOLD_ZERO:  slot_threshold[0] = cfg_data;
                    REG_THRESHOLD_ONE:   slot_threshold[1] = cfg_data;
                    REG_THRESHOLD_TWO:   slot_threshold[2] = cfg_data;
                    REG_THRESHOLD_THREE: slot_threshold[3] = cfg_data;
                    default: ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                if (expected_drive.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: drive word r=%0d g=%0d b=%0d arrived with none expected",
                                 $time, out_word.out_red, out_word.out_green,
                                 out_word.out_blue);
                end
                else
                begin
                    want = expected_drive.pop_front();
                    if (out_word.out_red !== want.out_red ||
                        out_word.out_green !== want.out_green ||
                        out_word.out_blue !== want.out_blue)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("%0t: drive word mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                     $time, want.out_red, want.out_green, want.out_blue,
                                     out_word.out_red, out_word.out_green,
                                     out_word.out_blue);
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                // A frame start steps the phase before this pixel uses it,
                // but only while dithering is on.
                if (in_word.frame_start && dither_on)
                    frame_phase = frame_phase + 1'b1;
                slot      = frame_phase + in_word.pixel_index[PHASE_W-1:0];
                threshold = slot_threshold[slot];
                drive.out_red   = scale_level(in_word.red_level, threshold, dither_on);
                drive.out_green = scale_level(in_word.green_level, threshold, dither_on);
                drive.out_blue  = scale_level(in_word.blue_level, threshold, dither_on);
                expected_drive.push_back(drive);
            end

            pending_words = expected_drive.size();
        end
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LED temporal dither quantizer testbench
// Drives pixel words through the quantizer under several register settings,
// with bursty input, a stalling output and one long output hold-off. A
// checker module beside the block predicts and compares every drive word.
// ---------------------------------------------------------------------------
module testbench;
    import ltdq_pkg::*;

    localparam int RESET_CYCLES  = 11;
    localparam int LIMIT_CYCLES  = 200000;
    // The pipeline is two stages deep, so a few quiet cycles cover it.
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 80;
    localparam int PHASE_WORDS   = 50;
    localparam int SETTING_COUNT = 8;

    // Indexes past the last register; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    localparam logic [FRAC_W-1:0]  THRESHOLD_MAX = 16'hFFFF;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 17'h1FFFF;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ltdq_pixel_in_if  pix_in_ch ();
    ltdq_pixel_out_if pix_out_ch ();

    int mismatch_count;
    int pending_words;
    int cycle_count = 0;
    int burst_left  = 0;
    bit hold_requested = 1'b0;

    always #6 clk = ~clk;

    led_temporal_dither_quantizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_in    (pix_in_ch),
        .pix_out   (pix_out_ch)
    );

    ltdq_drive_checker u_drive_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (pix_in_ch.valid),
        .in_ready       (pix_in_ch.ready),
        .in_word        (pix_in_ch.data),
        .out_valid      (pix_out_ch.valid),
        .out_ready      (pix_out_ch.ready),
        .out_word       (pix_out_ch.data),
        .mismatch_count (mismatch_count),
        .pending_words  (pending_words)
    );

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Output side. The ready pattern rotates in turn through always ready,
    // toggling, mostly ready and mostly stalled. Once the stimulus asks
    // for it, ready is held low for a long stretch so that the pipeline
    // fills and pushes back on the input while the sender keeps offering.
    initial
    begin : drive_sink
        int rx_cycle;
        bit hold_done;
        rx_cycle  = 0;
        hold_done = 1'b0;
        pix_out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (hold_requested && !hold_done)
            begin
                hold_done = 1'b1;
                pix_out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                case (rx_cycle[7:6])
                    2'd0:    pix_out_ch.ready <= 1'b1;
                    2'd1:    pix_out_ch.ready <= rx_cycle[0];
                    2'd2:    pix_out_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: pix_out_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Mostly in range, with zero, full scale, just below it and the clamped
    // region above it drawn often.
    function automatic logic [LEVEL_W-1:0] random_level();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return FULL_SCALE;
            2:       return LEVEL_W'($urandom_range(FULL_SCALE + 1, LEVEL_MAX));
            3:       return FULL_SCALE - 1'b1;
            default: return LEVEL_W'($urandom_range(0, FULL_SCALE));
        endcase
    endfunction

    function automatic pixel_in_t make_pixel(
        input int red,
        input int green,
        input int blue,
        input int index,
        input bit start
    );
        pixel_in_t word;
        word.red_level   = LEVEL_W'(red);
        word.green_level = LEVEL_W'(green);
        word.blue_level  = LEVEL_W'(blue);
        word.pixel_index = INDEX_W'(index);
        word.frame_start = start;
        return word;
    endfunction

    // Offer one pixel word and return at the edge that accepts it. The sender
    // runs in bursts; between bursts valid drops for a few cycles. Ready is
    // looked at on the falling edge, where it already holds the value that
    // the next rising edge sees.
    task automatic send_pixel(input pixel_in_t word);
        logic taken;
        if (burst_left == 0)
        begin
            pix_in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 12);
        end
        pix_in_ch.valid <= 1'b1;
        pix_in_ch.data  <= word;
        do
        begin
            @(negedge clk);
            taken = pix_in_ch.ready;
            @(posedge clk);
        end
        while (!taken);
        burst_left--;
    endtask

    // Stop offering and wait until every predicted drive word has come out,
    // then let the pipeline settle.
    task automatic wait_drained();
        pix_in_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_words != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write enable stays high across back-to-back writes; the caller lowers it.
    task automatic write_reg(
        input logic [CFG_IDX_W-1:0]  index,
        input logic [CFG_DATA_W-1:0] value
    );
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Registers change only with the block idle. The enable is written with
    // random upper bits, since only bit zero counts, and one unmapped index
    // gets a random value that must be ignored.
    task automatic apply_settings(
        input logic              dither,
        input logic [FRAC_W-1:0] slot0,
        input logic [FRAC_W-1:0] slot1,
        input logic [FRAC_W-1:0] slot2,
        input logic [FRAC_W-1:0] slot3
    );
        logic [CFG_IDX_W-1:0] spare;
        spare = CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST));
        wait_drained();
        write_reg(REG_DITHER_ENABLE, {15'($urandom), dither});
        write_reg(REG_THRESHOLD_ZERO, slot0);
        write_reg(REG_THRESHOLD_ONE, slot1);
        write_reg(REG_THRESHOLD_TWO, slot2);
        write_reg(REG_THRESHOLD_THREE, slot3);
        write_reg(spare, 16'($urandom));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_directed();
        // Reset settings: dither on, default thresholds. Zero and full scale,
        // then levels above full scale that must clamp.
        send_pixel(make_pixel(0, 0, 0, 0, 1'b1));
        send_pixel(make_pixel(65536, 65536, 65536, 1, 1'b0));
        send_pixel(make_pixel(65537, 131071, 100000, 2, 1'b0));
        send_pixel(make_pixel(65535, 1, 32768, 3, 1'b0));
        // Only the low two index bits choose the slot, so the top of the
        // index range behaves like any other index.
        send_pixel(make_pixel(32768, 32767, 258, 1023, 1'b0));
        send_pixel(make_pixel('h15555, 'h0AAAA, 'h1FFFF, 'h2AA, 1'b1));
        send_pixel(make_pixel('h0AAAA, 'h15555, 0, 'h155, 1'b1));
        // Frame starts back to back walk the phase all the way around.
        repeat (4) send_pixel(make_pixel(40000, 20000, 60000, 0, 1'b1));

        // With every threshold at zero a full-scale level rounds up to 255.
        apply_settings(1'b1, '0, '0, '0, '0);
        send_pixel(make_pixel(65536, 0, 131071, 2, 1'b0));
        send_pixel(make_pixel(65536, 65536, 1, 3, 1'b1));

        // Plain truncation; frame starts must leave the phase alone here.
        apply_settings(1'b0, THRESHOLD_ZERO_RST, THRESHOLD_ONE_RST,
                       THRESHOLD_TWO_RST, THRESHOLD_THREE_RST);
        send_pixel(make_pixel(65536, 65535, 256, 0, 1'b1));
        send_pixel(make_pixel(131071, 1, 32768, 3, 1'b1));
    endtask

    // Well-formed frames of random length, indexes counting up from zero
    // with a frame start on the first pixel, sprinkled with stray words that
    // carry a random index and a random frame start.
    task automatic run_frames(input int count);
        int        sent;
        int        frame_len;
        int        pos;
        pixel_in_t word;
        sent = 0;
        while (sent < count)
        begin
            frame_len = $urandom_range(1, 40);
            for (pos = 0; pos < frame_len && sent < count; pos++)
            begin
                word.red_level   = random_level();
                word.green_level = random_level();
                word.blue_level  = random_level();
                if ($urandom_range(0, 9) == 0)
                begin
                    word.pixel_index = INDEX_W'($urandom);
                    word.frame_start = 1'($urandom);
                end
                else
                begin
                    word.pixel_index = INDEX_W'(pos);
                    word.frame_start = (pos == 0);
                end
                send_pixel(word);
                sent++;
            end
        end
    endtask

    initial
    begin : stimulus
        int setting;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= REG_DITHER_ENABLE;
        cfg_data        <= '0;
        pix_in_ch.valid <= 1'b0;
        pix_in_ch.data  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // Each setting runs a batch of random frames. The extremes of the
        // threshold range and both modes come round more than once.
        for (setting = 0; setting < SETTING_COUNT; setting++)
        begin
            case (setting)
                0: apply_settings(1'b1, THRESHOLD_ZERO_RST, THRESHOLD_ONE_RST,
                                  THRESHOLD_TWO_RST, THRESHOLD_THREE_RST);
                1: apply_settings(1'b0, 16'($urandom), 16'($urandom),
                                  16'($urandom), 16'($urandom));
                2: apply_settings(1'b1, '0, '0, '0, '0);
                3: apply_settings(1'b1, THRESHOLD_MAX, THRESHOLD_MAX,
                                  THRESHOLD_MAX, THRESHOLD_MAX);
                4: apply_settings(1'b1, 16'($urandom), 16'($urandom),
                                  16'($urandom), 16'($urandom));
                5: apply_settings(1'b0, '0, '0, '0, '0);
                6: apply_settings(1'b1, '0, THRESHOLD_MAX, 16'd1,
                                  THRESHOLD_MAX - 1'b1);
                default: apply_settings(1'b1, 16'($urandom), 16'($urandom),
                                        16'($urandom), 16'($urandom));
            endcase
            // The long output hold-off falls inside the first random batch.
            if (setting == 0)
                hold_requested = 1'b1;
            run_frames(PHASE_WORDS);
        end

        wait_drained();
        if (mismatch_count == 0 && pending_words == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[led_temporal_dither_quantizer.f]
sv/ltdq_pkg.sv
sv/ltdq_pixel_in_if.sv
sv/ltdq_pixel_out_if.sv
sv/ltdq_channel_quant.sv
sv/led_temporal_dither_quantizer.sv
sim/ltdq_drive_checker.sv
sim/testbench.sv
